// ----- rtl/core/sidta_pkg.sv -----
`timescale 1ns / 1ps

package sidta_pkg;

   localparam int VALUE_W = 32;
   localparam int DIGITS = 10;
   localparam int DIGIT_IDX_W = $clog2(DIGITS);
   localparam int STEP_W = $clog2(VALUE_W);
   localparam int CHAR_W = 6;

   localparam logic [CHAR_W-1:0] CHR_ZERO = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHR_MINUS = CHAR_W'(45);

   typedef logic [DIGITS-1:0][3:0] bcd_type;
   typedef logic [DIGIT_IDX_W-1:0] digit_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

// Converts one signed 32-bit integer per transaction into its decimal ASCII text,
// most significant character first, one character per output transaction, with
// rsp_last set on the final character. Negative numbers start with '-', zero
// gives "0", and -2147483648 is handled. The block takes one number at a time:
// after acceptance it runs a 32-step shift-and-add-3 binary-to-BCD loop with one
// digit-adjust unit per BCD digit, then sends 1 to 11 characters at one per
// cycle while rsp_stall is low.
module signed_int_to_decimal_ascii (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [sidta_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sidta_pkg::CHAR_W-1:0]      rsp_character,
   output logic                              rsp_last
);
   import sidta_pkg::*;

   state_type          state_ff, state_in;
   logic               conv_start;
   logic               conv_done;
   bcd_type            bcd;
   logic [VALUE_W-1:0] raw;
   logic [VALUE_W-1:0] magnitude;
   logic               accept;
   logic               out_free;
   logic               load_char;
   logic               sign_pend_ff, sign_pend_in;
   digit_idx_type      idx_ff, idx_in;
   digit_idx_type      top_idx;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   assign raw       = req_value;
   assign magnitude = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sidta_bcd_unit u_bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .magnitude (magnitude),
      .done      (conv_done),
      .bcd       (bcd)
   );

   // position of the most significant nonzero digit, zero for a zero value
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[i] != 4'd0) begin
            top_idx = DIGIT_IDX_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (conv_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && !sign_pend_ff && idx_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall  = 1'b1;
      accept     = 1'b0;
      conv_start = 1'b0;
      load_char  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            accept     = req_valid;
            conv_start = req_valid;
         end
         ST_CONV: ;
         ST_EMIT: begin
            load_char = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      sign_pend_in = sign_pend_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         sign_pend_in = raw[VALUE_W-1];
      end
      if (state_ff == ST_CONV && conv_done) begin
         idx_in = top_idx;
      end
      if (load_char) begin
         rsp_valid_in = 1'b1;
         if (sign_pend_ff) begin
            char_in      = CHR_MINUS;
            last_in      = 1'b0;
            sign_pend_in = 1'b0;
         end else begin
            char_in = CHR_ZERO + CHAR_W'(bcd[idx_ff]);
            last_in = (idx_ff == '0);
            if (idx_ff != '0) idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_pend_ff <= sign_pend_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- rtl/core/sidta_bcd_unit.sv -----
`timescale 1ns / 1ps

module sidta_bcd_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sidta_pkg::VALUE_W-1:0]   magnitude,
   output logic                            done,
   output sidta_pkg::bcd_type              bcd
);
   import sidta_pkg::*;

   logic [VALUE_W-1:0]          bin_ff, bin_in;
   bcd_type                     bcd_ff, bcd_in;
   bcd_type                     adjusted;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [4*DIGITS+VALUE_W-1:0] shifted;

   // shift-and-add-3: every digit of 5 or more gets 3 before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adjusted[i] = (bcd_ff[i] >= 4'd5) ? (bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
      shifted = {adjusted, bin_ff} << 1;
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = magnitude;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = shifted[VALUE_W-1:0];
         bcd_in  = shifted[4*DIGITS+VALUE_W-1:VALUE_W];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ----- rtl/core/sidta_checker.sv -----
`timescale 1ns / 1ps

module sidta_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [sidta_pkg::CHAR_W-1:0]      rsp_character,
   input logic                              rsp_last
);
   import sidta_pkg::*;

   // a stalled result transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled result changed");

   // one number at a time: busy right after an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a second number while converting");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_character == CHR_MINUS
                 || (rsp_character >= CHR_ZERO && rsp_character <= CHR_ZERO + CHAR_W'(9)))
      else $error("character is not a sign or a digit");

   // the sign is always followed by at least one digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHR_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);
